FILE: hdl/buffered_uart_ring_fifos_top_defines.svh
// assertion macros for the buffered uart ring block and its checker
// depends on a clk_i and rst_ni in scope where the macros are used
`ifndef BUFFERED_UART_RING_FIFOS_TOP_DEFINES_SVH
`define BUFFERED_UART_RING_FIFOS_TOP_DEFINES_SVH

// checked only out of reset
`define BUFUART_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define BUFUART_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/bufuart_pkg.sv
// shared types and constants for the buffered uart ring block
// no dependencies
`default_nettype none

package bufuart_pkg;

  localparam int unsigned RxDepthDef = 64;
  localparam int unsigned TxDepthDef = 64;

  typedef enum logic [1:0] {
    CMD_RX_BYTE  = 2'd0,
    CMD_HOST_RD  = 2'd1,
    CMD_HOST_WR  = 2'd2,
    CMD_TX_READY = 2'd3
  } cmd_e;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_OVERFLOW = 3'd4;

  typedef enum logic {
    S_IDLE,
    S_LOAD
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic take;  // input beat accepted, update rings
    logic load;  // move pending result into output register
  } bufuart_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/bufuart_ctrl.sv
// handshake controller for the buffered uart ring block
// depends on bufuart_pkg
`default_nettype none

module bufuart_ctrl
  import bufuart_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output bufuart_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.take = in_valid_i;
      end
      S_LOAD: begin
        cmd_o.load = out_free;
        if (out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: hdl/bufuart_dp.sv
// ring pointers, byte stores, error register and result register
// depends on bufuart_pkg
`default_nettype none

module bufuart_dp
  import bufuart_pkg::*;
#(
  parameter int unsigned RX_DEPTH = RxDepthDef,
  parameter int unsigned TX_DEPTH = TxDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  bufuart_cmd_t cmd_i,
  input  logic [1:0]   command_i,
  input  logic [7:0]   data_i,
  input  logic         frame_error_i,
  input  logic         data_overrun_i,
  input  logic         transmitter_empty_i,
  output logic [7:0]   read_byte_o,
  output logic         rx_has_data_o,
  output logic         send_valid_o,
  output logic [7:0]   send_byte_o,
  output logic         write_accepted_o,
  output logic [2:0]   error_code_o,
  output logic         busy_res_o
);

  localparam int unsigned RxAw = (RX_DEPTH > 2) ? $clog2(RX_DEPTH) : 1;
  localparam int unsigned TxAw = (TX_DEPTH > 2) ? $clog2(TX_DEPTH) : 1;
  localparam logic [RxAw-1:0] RxLast = RxAw'(RX_DEPTH - 1);
  localparam logic [TxAw-1:0] TxLast = TxAw'(TX_DEPTH - 1);

  logic [7:0] rx_mem_q [RX_DEPTH];
  logic [7:0] tx_mem_q [TX_DEPTH];
  logic [7:0] rx_rd_q, tx_rd_q;

  logic [RxAw-1:0] rx_wp_q, rx_wp_d, rx_rp_q, rx_rp_d, rx_wn, rx_rn;
  logic [TxAw-1:0] tx_wp_q, tx_wp_d, tx_rp_q, tx_rp_d, tx_wn, tx_rn;
  logic [2:0]      err_q, err_d;
  logic            tx_en_q, tx_en_d;
  logic            rx_we, rx_re, tx_we, tx_re, wr_ok;

  // pending result, held between accept and output load
  logic pend_rx_q, pend_tx_q, pend_wa_q, pend_txe_q;

  logic [7:0] read_byte_q, send_byte_q;
  logic       rx_has_q, send_valid_q, wa_q, busy_q;
  logic [2:0] err_out_q;

  assign rx_wn = (rx_wp_q == RxLast) ? '0 : rx_wp_q + 1'b1;
  assign rx_rn = (rx_rp_q == RxLast) ? '0 : rx_rp_q + 1'b1;
  assign tx_wn = (tx_wp_q == TxLast) ? '0 : tx_wp_q + 1'b1;
  assign tx_rn = (tx_rp_q == TxLast) ? '0 : tx_rp_q + 1'b1;

  always_comb begin
    rx_wp_d = rx_wp_q;
    rx_rp_d = rx_rp_q;
    tx_wp_d = tx_wp_q;
    tx_rp_d = tx_rp_q;
    err_d   = err_q;
    tx_en_d = tx_en_q;
    rx_we   = 1'b0;
    rx_re   = 1'b0;
    tx_we   = 1'b0;
    tx_re   = 1'b0;
    wr_ok   = 1'b0;
    if (cmd_i.take) begin
      case (cmd_e'(command_i))
        CMD_RX_BYTE: begin
          if (rx_wn == rx_rp_q) begin
            err_d = ERR_OVERFLOW;
          end else begin
            rx_wp_d = rx_wn;
            rx_we   = 1'b1;
            err_d   = {1'b0, data_overrun_i, frame_error_i};
          end
        end
        CMD_HOST_RD: begin
          if (rx_wp_q != rx_rp_q) begin
            rx_rp_d = rx_rn;
            rx_re   = 1'b1;
          end
        end
        CMD_HOST_WR: begin
          if (tx_wn != tx_rp_q) begin
            tx_wp_d = tx_wn;
            tx_we   = 1'b1;
            tx_en_d = 1'b1;
            wr_ok   = 1'b1;
          end
        end
        CMD_TX_READY: begin
          if (tx_wp_q != tx_rp_q) begin
            tx_rp_d = tx_rn;
            tx_re   = 1'b1;
          end else begin
            tx_en_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wp_q <= '0;
      rx_rp_q <= '0;
      tx_wp_q <= '0;
      tx_rp_q <= '0;
      err_q   <= ERR_NONE;
      tx_en_q <= 1'b0;
    end else begin
      rx_wp_q <= rx_wp_d;
      rx_rp_q <= rx_rp_d;
      tx_wp_q <= tx_wp_d;
      tx_rp_q <= tx_rp_d;
      err_q   <= err_d;
      tx_en_q <= tx_en_d;
    end
  end

  // byte stores, registered read
  always_ff @(posedge clk_i) begin
    if (rx_we) rx_mem_q[rx_wn] <= data_i;
    if (rx_re) rx_rd_q <= rx_mem_q[rx_rn];
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) tx_mem_q[tx_wn] <= data_i;
    if (tx_re) tx_rd_q <= tx_mem_q[tx_rn];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      pend_rx_q  <= rx_re;
      pend_tx_q  <= tx_re;
      pend_wa_q  <= wr_ok;
      pend_txe_q <= transmitter_empty_i;
    end
  end

  // pointers do not move between accept and load
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      read_byte_q  <= pend_rx_q ? rx_rd_q : 8'h00;
      rx_has_q     <= rx_wp_q != rx_rp_q;
      send_valid_q <= pend_tx_q;
      send_byte_q  <= pend_tx_q ? tx_rd_q : 8'h00;
      wa_q         <= pend_wa_q;
      err_out_q    <= err_q;
      busy_q       <= (tx_wp_q != tx_rp_q) || !pend_txe_q;
    end
  end

  assign read_byte_o      = read_byte_q;
  assign rx_has_data_o    = rx_has_q;
  assign send_valid_o     = send_valid_q;
  assign send_byte_o      = send_byte_q;
  assign write_accepted_o = wa_q;
  assign error_code_o     = err_out_q;
  assign busy_res_o       = busy_q;

endmodule

`default_nettype wire

FILE: hdl/buffered_uart_ring_fifos_top.sv
// buffered uart ring block: receive and transmit byte rings with host access
// instantiates bufuart_ctrl and bufuart_dp, depends on bufuart_pkg
//
// one input channel (in_valid_i / in_stall_o) carries events: a line byte
// received, a host read, a host write, or a transmitter-ready event. one
// output channel (out_valid_o / out_stall_i) returns exactly one result beat
// per event: the byte read, the byte handed to the transmitter, whether a
// host write was stored, the error register and the ring status flags.
// each event has an accept step and a load step: the accept step updates the
// ring pointers and starts the registered store read, the load step moves the
// result into the output register once the output is free. the block takes no
// new event until the result of the previous one has been loaded.
// a result stalled at the output is held in the output register; the block
// still accepts one more event, then stalls its input and keeps that event's
// result pending until the output frees.
// reset clears the ring pointers, the error register and the transmit event
// enable; both rings come up empty. store contents are not cleared.
`default_nettype none

module buffered_uart_ring_fifos_top
  import bufuart_pkg::*;
#(
  parameter int unsigned RX_DEPTH = RxDepthDef,
  parameter int unsigned TX_DEPTH = TxDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [7:0] data_i,
  input  logic       frame_error_i,
  input  logic       data_overrun_i,
  input  logic       transmitter_empty_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_byte_o,
  output logic       rx_has_data_o,
  output logic       send_valid_o,
  output logic [7:0] send_byte_o,
  output logic       write_accepted_o,
  output logic [2:0] error_code_o,
  output logic       busy_res_o
);

  bufuart_cmd_t cmd;

  bufuart_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  bufuart_dp #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .command_i           (command_i),
    .data_i              (data_i),
    .frame_error_i       (frame_error_i),
    .data_overrun_i      (data_overrun_i),
    .transmitter_empty_i (transmitter_empty_i),
    .read_byte_o         (read_byte_o),
    .rx_has_data_o       (rx_has_data_o),
    .send_valid_o        (send_valid_o),
    .send_byte_o         (send_byte_o),
    .write_accepted_o    (write_accepted_o),
    .error_code_o        (error_code_o),
    .busy_res_o          (busy_res_o)
  );

endmodule

`default_nettype wire

FILE: hdl/bufuart_chk.sv
// port-level checks for the buffered uart ring block, bound to the top level
// depends on buffered_uart_ring_fifos_top_defines.svh
`default_nettype none
`include "buffered_uart_ring_fifos_top_defines.svh"

module bufuart_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_i,
  input logic       out_valid_i,
  input logic       out_stall_i,
  input logic       send_valid_i,
  input logic [7:0] read_byte_i,
  input logic       write_accepted_i,
  input logic       busy_res_i
);

  // stalled result beat holds
  `BUFUART_ASSERT(a_out_hold, out_valid_i && out_stall_i |=> out_valid_i && $stable(read_byte_i), "stalled result beat changed")

  // one event in flight: input stalls right after a beat is taken
  `BUFUART_ASSERT(a_in_one, in_valid_i && !in_stall_i |=> in_stall_i, "input taken twice in a row")

  // a stored host write leaves the transmit ring busy
  `BUFUART_ASSERT(a_wr_busy, out_valid_i && write_accepted_i |-> busy_res_i && !send_valid_i, "accepted write without busy")

  // an edge seen in reset clears the result valid
  `BUFUART_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_i, "result valid in reset")

endmodule

bind buffered_uart_ring_fifos_top bufuart_chk u_bufuart_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_i       (in_stall_o),
  .out_valid_i      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .send_valid_i     (send_valid_o),
  .read_byte_i      (read_byte_o),
  .write_accepted_i (write_accepted_o),
  .busy_res_i       (busy_res_o)
);

`default_nettype wire

FILE: tb/sv/uart_ring_sb_pkg.sv
// scoreboard for the buffered uart ring block: ring predictor and result checks
// depends on bufuart_pkg for the command codes, depths and error codes
package uart_ring_sb_pkg;
  import bufuart_pkg::*;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       rx_has_data;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       write_accepted;
    logic [2:0] error_code;
    logic       busy_res;
  } uart_result_t;

  localparam int unsigned MaxPrinted = 40;

  class uart_ring_sb;
    logic [7:0]  rx_bytes [RxDepthDef];
    logic [7:0]  tx_bytes [TxDepthDef];
    int unsigned rx_head, rx_tail, tx_head, tx_tail;
    logic [2:0]  err_reg;
    bit          tx_irq_en;
    uart_result_t pending [$];

    int unsigned n_events, n_results, n_mismatches;
    int unsigned n_overflows, n_refused, n_empty_reads, n_tx_idle, n_sent;

    function new();
      rx_head = 0;
      rx_tail = 0;
      tx_head = 0;
      tx_tail = 0;
      err_reg = ERR_NONE;
      tx_irq_en = 1'b0;
    endfunction

    static function int unsigned advance(int unsigned p, int unsigned depth);
      return (p + 1 >= depth) ? 0 : p + 1;
    endfunction

    // one input beat accepted: update the rings and queue the result it causes
    function void note_event(cmd_e cmd, logic [7:0] data, logic fe, logic dor, logic txe);
      uart_result_t r;
      int unsigned  nxt;
      r = '0;
      case (cmd)
        CMD_RX_BYTE: begin
          nxt = advance(rx_head, RxDepthDef);
          if (nxt == rx_tail) begin
            err_reg = ERR_OVERFLOW;
            n_overflows++;
          end else begin
            rx_head = nxt;
            rx_bytes[nxt] = data;
            err_reg = {1'b0, dor, fe};
          end
        end
        CMD_HOST_RD: begin
          if (rx_head != rx_tail) begin
            rx_tail = advance(rx_tail, RxDepthDef);
            r.read_byte = rx_bytes[rx_tail];
          end else begin
            n_empty_reads++;
          end
        end
        CMD_HOST_WR: begin
          nxt = advance(tx_head, TxDepthDef);
          if (nxt != tx_tail) begin
            tx_bytes[nxt] = data;
            tx_head = nxt;
            tx_irq_en = 1'b1;
            r.write_accepted = 1'b1;
          end else begin
            n_refused++;
          end
        end
        default: begin
          if (tx_head != tx_tail) begin
            tx_tail = advance(tx_tail, TxDepthDef);
            r.send_valid = 1'b1;
            r.send_byte = tx_bytes[tx_tail];
            n_sent++;
          end else begin
            tx_irq_en = 1'b0;
            n_tx_idle++;
          end
        end
      endcase
      r.rx_has_data = (rx_head != rx_tail);
      r.error_code = err_reg;
      r.busy_res = (tx_head != tx_tail) || !txe;
      pending.push_back(r);
      n_events++;
    endfunction

    task report(string what);
      n_mismatches++;
      if (n_mismatches <= MaxPrinted) begin
        $display("mismatch: %s", what);
      end else if (n_mismatches == MaxPrinted + 1) begin
        $display("mismatch: further mismatches are counted but not printed");
      end
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
        report($sformatf("result %0d %s got %0h want %0h", n_results, name, got, want));
      end
    endtask

    task check_result(uart_result_t got);
      uart_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", n_results));
      end else begin
        want = pending.pop_front();
        compare_field("read_byte", got.read_byte, want.read_byte);
        compare_field("rx_has_data", got.rx_has_data, want.rx_has_data);
        compare_field("send_valid", got.send_valid, want.send_valid);
        compare_field("send_byte", got.send_byte, want.send_byte);
        compare_field("write_accepted", got.write_accepted, want.write_accepted);
        compare_field("error_code", got.error_code, want.error_code);
        compare_field("busy_res", got.busy_res, want.busy_res);
      end
      n_results++;
    endtask
  endclass

endpackage

FILE: tb/sv/tb_buffered_uart_ring_fifos_top.sv
// testbench top for buffered_uart_ring_fifos_top: drives event beats, checks result beats
// depends on bufuart_pkg, uart_ring_sb_pkg and the block rtl
module tb_buffered_uart_ring_fifos_top;
  import bufuart_pkg::*;
  import uart_ring_sb_pkg::*;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned ItemsPerRegime = 370;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] command = CMD_HOST_RD;
  logic [7:0] data = 8'h00;
  logic       frame_error = 1'b0;
  logic       data_overrun = 1'b0;
  logic       transmitter_empty = 1'b1;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] read_byte;
  logic       rx_has_data;
  logic       send_valid;
  logic [7:0] send_byte;
  logic       write_accepted;
  logic [2:0] error_code;
  logic       busy_res;
  uart_result_t result_beat;

  uart_ring_sb ring_sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned quiet = 0;
  int unsigned idle_plan [4] = '{0, 85, 0, 36};
  int unsigned stall_plan [4] = '{0, 0, 85, 36};

  buffered_uart_ring_fifos_top DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .command_i           (command),
    .data_i              (data),
    .frame_error_i       (frame_error),
    .data_overrun_i      (data_overrun),
    .transmitter_empty_i (transmitter_empty),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .read_byte_o         (read_byte),
    .rx_has_data_o       (rx_has_data),
    .send_valid_o        (send_valid),
    .send_byte_o         (send_byte),
    .write_accepted_o    (write_accepted),
    .error_code_o        (error_code),
    .busy_res_o          (busy_res)
  );

  assign result_beat = {read_byte, rx_has_data, send_valid, send_byte,
                        write_accepted, error_code, busy_res};

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // offer one event beat, idling first at the current rate, and hold it until taken
  task automatic send_event(cmd_e c, logic [7:0] d, logic fe, logic dor, logic txe);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    command <= c;
    data <= d;
    frame_error <= fe;
    data_overrun <= dor;
    transmitter_empty <= txe;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    ring_sb.note_event(c, d, fe, dor, txe);
  endtask

  task automatic send_random(cmd_e favored, int unsigned favor_pct);
    cmd_e       c;
    logic [7:0] d;
    logic       fe, dor, txe;
    if ($urandom_range(99) < favor_pct) c = favored;
    else c = cmd_e'($urandom_range(3));
    d = $urandom_range(255);
    fe = $urandom_range(1);
    dor = $urandom_range(1);
    txe = $urandom_range(1);
    send_event(c, d, fe, dor, txe);
  endtask

  // bursts that fill or drain one ring, mixed with stretches of random commands
  task automatic run_random(int unsigned count);
    int unsigned done_items, kind, len, i;
    done_items = 0;
    while (done_items < count) begin
      kind = $urandom_range(9);
      len = (kind < 7) ? $urandom_range(70, 45) : $urandom_range(30, 8);
      for (i = 0; i < len; i++) begin
        case (kind)
          0, 1: send_random(CMD_RX_BYTE, 90);
          2, 3: send_random(CMD_HOST_RD, 90);
          4, 5: send_random(CMD_HOST_WR, 90);
          6: send_random(CMD_TX_READY, 90);
          default: send_random(CMD_RX_BYTE, 0);
        endcase
      end
      done_items += len;
    end
  endtask

  // result side: check each taken beat, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) ring_sb.check_result(result_beat);
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no beat moved for %0d cycles", QuietLimit);
    $display("** buffered_uart_ring_fifos_top: FAILED **");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty rings: transmitter ready and host read with nothing queued
    send_event(CMD_TX_READY, 8'h00, 1'b0, 1'b0, 1'b1);
    send_event(CMD_TX_READY, 8'hFF, 1'b1, 1'b1, 1'b0);
    send_event(CMD_HOST_RD, 8'h3C, 1'b1, 1'b0, 1'b1);
    // every error flag combination on arrival
    send_event(CMD_RX_BYTE, 8'h00, 1'b0, 1'b0, 1'b0);
    send_event(CMD_RX_BYTE, 8'hFF, 1'b1, 1'b0, 1'b1);
    send_event(CMD_RX_BYTE, 8'hA5, 1'b0, 1'b1, 1'b0);
    send_event(CMD_RX_BYTE, 8'h5A, 1'b1, 1'b1, 1'b1);
    repeat (5) send_event(CMD_HOST_RD, 8'hC3, 1'b0, 1'b1, 1'b0);
    send_event(CMD_HOST_WR, 8'h00, 1'b1, 1'b1, 1'b0);
    send_event(CMD_HOST_WR, 8'hFF, 1'b0, 1'b0, 1'b1);
    send_event(CMD_HOST_WR, 8'h81, 1'b1, 1'b0, 1'b0);
    send_event(CMD_TX_READY, 8'h7E, 1'b0, 1'b1, 1'b0);
    send_event(CMD_TX_READY, 8'h18, 1'b1, 1'b1, 1'b1);
    send_event(CMD_TX_READY, 8'hE7, 1'b0, 1'b0, 1'b0);
    send_event(CMD_TX_READY, 8'h42, 1'b1, 1'b0, 1'b1);

    for (int r = 0; r < 4; r++) begin
      send_idle_pct = idle_plan[r];
      stall_pct = stall_plan[r];
      // long output hold-off while events keep coming, so the input stalls
      if (idle_plan[r] == stall_plan[r]) hold_request = HoldCycles;
      run_random(ItemsPerRegime);
    end
    in_valid <= 1'b0;

    while (ring_sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d event beats and %0d result beats under four idle and stall regimes",
             ring_sb.n_events, ring_sb.n_results);
    $display("rx overflows %0d, refused writes %0d, empty reads %0d, idle tx-ready %0d, sent %0d",
             ring_sb.n_overflows, ring_sb.n_refused, ring_sb.n_empty_reads,
             ring_sb.n_tx_idle, ring_sb.n_sent);
    if (ring_sb.n_mismatches == 0) begin
      $display("** buffered_uart_ring_fifos_top: PASSED **");
    end else begin
      $display("** buffered_uart_ring_fifos_top: FAILED **");
    end
    $finish;
  end

endmodule
